FILE: src/tdbl_pkg.sv
package tdbl_pkg;

    localparam int NODE_COUNT_DEF = 65536;
    localparam int LEVELS_DEF     = 16;

    localparam int NODE_W  = 16;
    localparam int DEPTH_W = 16;
    localparam int PATH_W  = 17;
    localparam int LVL_W   = 5;

    localparam logic [PATH_W-1:0] PATH_MAX = '1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [NODE_W-1:0] first_node;
        logic [NODE_W-1:0] second_node;
    } item_t;

    typedef struct packed {
        logic [PATH_W-1:0] path_length;
    } result_t;

    typedef struct packed {
        logic [NODE_W-1:0]  rd_node_a;
        logic [NODE_W-1:0]  rd_node_b;
        logic [LVL_W-1:0]   rd_lvl;
        logic               anc_we;
        logic               dep_we;
        logic [NODE_W-1:0]  wr_node;
        logic [LVL_W-1:0]   wr_lvl;
        logic [NODE_W-1:0]  wr_anc;
        logic [DEPTH_W-1:0] wr_depth;
    } store_req_t;

    typedef struct packed {
        logic [NODE_W-1:0]  anc_a;
        logic [NODE_W-1:0]  anc_b;
        logic [DEPTH_W-1:0] dep_a;
        logic [DEPTH_W-1:0] dep_b;
    } store_rsp_t;

    // node numbers outside the table fold onto the sentinel
    function automatic logic [NODE_W-1:0] clip_node(logic [NODE_W-1:0] x, int unsigned count);
        logic [31:0] wide;
        wide = {{(32 - NODE_W){1'b0}}, x};
        return (wide < count) ? x : '0;
    endfunction

endpackage

FILE: src/tdbl_chan_if.sv
interface tdbl_chan_if #(
    parameter type data_t = logic
) ();

    logic  valid;
    logic  ready;
    data_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

FILE: src/tree_distance_binary_lifting.sv
// tree distance by binary lifting
// item channel (sink): cmd, first_node, second_node. cmd insert stores first_node
// under parent second_node (0 for a root); cmd query asks for the edge count between
// first_node and second_node. result channel (source): path_length, one transaction
// per query, none per insert.
// an insert runs one depth read, then one ancestor level a cycle,
// each level addressed by the ancestor read the cycle before.
// a query runs depth reads, LEVELS lift steps, a meet check and, when the nodes have not
// met, LEVELS climb steps on the dual-read ancestor memory, up to the output register.
// item ready is high only while the sequencer is idle; a query that meets at once
// still runs its lift steps.
// the result sits in an output register; the next item is accepted while it waits.
// a finished query holds in its last step until that register is free.
// reset clears the sequencer and the result valid; the memories are not cleared,
// node 0 reads as the sentinel, so the block is ready in the first cycle after reset.
module tree_distance_binary_lifting #(
    parameter int NODE_COUNT = tdbl_pkg::NODE_COUNT_DEF,
    parameter int LEVELS     = tdbl_pkg::LEVELS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    tdbl_chan_if.sink   item,
    tdbl_chan_if.source result
);

    import tdbl_pkg::*;

    localparam int TW = ((LEVELS + 1 > PATH_W) ? LEVELS + 1 : PATH_W) + 1;
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_DEPTH,
        S_INS_LEVEL,
        S_Q_DEPTH,
        S_Q_LIFT,
        S_Q_MEET,
        S_Q_CLIMB,
        S_Q_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [NODE_W-1:0]  a_reg, a_next;
    logic [NODE_W-1:0]  b_reg, b_next;
    logic [NODE_W-1:0]  n_reg, n_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [DEPTH_W-1:0] gap_reg, gap_next;
    logic [TW-1:0]      total_reg, total_next;
    logic [PATH_W-1:0]  res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic [PATH_W-1:0]  out_data_reg, out_data_next;

    store_req_t req;
    store_rsp_t rsp;

    logic [NODE_W-1:0]  first_clip;
    logic [NODE_W-1:0]  second_clip;
    logic [NODE_W-1:0]  anc_next;
    logic [DEPTH_W-1:0] gap_shift;
    logic               swap;
    logic [NODE_W-1:0]  lift_a;
    logic [TW-1:0]      climb_total;

    tdbl_store #(
        .NODE_COUNT(NODE_COUNT),
        .LEVELS    (LEVELS)
    ) u_store (
        .clk(clk),
        .req(req),
        .rsp(rsp)
    );

    assign first_clip  = clip_node(item.data.first_node, NODE_COUNT);
    assign second_clip = clip_node(item.data.second_node, NODE_COUNT);

    assign item.ready               = (state_reg == S_IDLE);
    assign result.valid             = out_valid_reg;
    assign result.data.path_length  = out_data_reg;

    // a row read in the cycle it is written returns stale data
    assign anc_next    = (a_reg == n_reg) ? a_reg : rsp.anc_a;
    assign swap        = (rsp.dep_a < rsp.dep_b);
    assign gap_shift   = gap_reg >> lvl_reg;
    assign lift_a      = gap_shift[0] ? rsp.anc_a : a_reg;
    assign climb_total = (rsp.anc_a != rsp.anc_b) ? total_reg + (TW'(2) << lvl_reg)
                                                  : total_reg;

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        n_next         = n_reg;
        lvl_next       = lvl_reg;
        gap_next       = gap_reg;
        total_next     = total_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next  = out_data_reg;
        req            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.data.cmd == CMD_INSERT)
                    begin
                        if (first_clip != '0)
                        begin
                            n_next        = first_clip;
                            a_next        = second_clip;
                            req.rd_node_a = second_clip;
                            state_next    = S_INS_DEPTH;
                        end
                    end
                    else
                    begin
                        a_next        = first_clip;
                        b_next        = second_clip;
                        req.rd_node_a = first_clip;
                        req.rd_node_b = second_clip;
                        state_next    = S_Q_DEPTH;
                    end
                end
            end

            S_INS_DEPTH:
            begin
                req.dep_we    = 1'b1;
                req.anc_we    = 1'b1;
                req.wr_node   = n_reg;
                req.wr_lvl    = '0;
                req.wr_anc    = a_reg;
                req.wr_depth  = rsp.dep_a + DEPTH_W'(1);
                req.rd_node_a = a_reg;
                req.rd_lvl    = '0;
                lvl_next      = LVL_W'(1);
                state_next    = S_INS_LEVEL;
            end

            S_INS_LEVEL:
            begin
                req.anc_we  = 1'b1;
                req.wr_node = n_reg;
                req.wr_lvl  = lvl_reg;
                req.wr_anc  = anc_next;
                a_next      = anc_next;
                if (lvl_reg == LVL_TOP)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    req.rd_node_a = anc_next;
                    req.rd_lvl    = lvl_reg;
                    lvl_next      = lvl_reg + LVL_W'(1);
                end
            end

            S_Q_DEPTH:
            begin
                a_next        = swap ? b_reg : a_reg;
                b_next        = swap ? a_reg : b_reg;
                gap_next      = swap ? rsp.dep_b - rsp.dep_a : rsp.dep_a - rsp.dep_b;
                lvl_next      = LVL_TOP;
                req.rd_node_a = swap ? b_reg : a_reg;
                req.rd_lvl    = LVL_TOP;
                state_next    = S_Q_LIFT;
            end

            S_Q_LIFT:
            begin
                a_next = lift_a;
                if (lvl_reg == '0)
                begin
                    state_next = S_Q_MEET;
                end
                else
                begin
                    req.rd_node_a = lift_a;
                    req.rd_lvl    = lvl_reg - LVL_W'(1);
                    lvl_next      = lvl_reg - LVL_W'(1);
                end
            end

            S_Q_MEET:
            begin
                if (a_reg == b_reg)
                begin
                    res_next   = PATH_W'(gap_reg);
                    state_next = S_Q_EMIT;
                end
                else
                begin
                    total_next    = TW'(gap_reg) + TW'(2);
                    lvl_next      = LVL_TOP;
                    req.rd_node_a = a_reg;
                    req.rd_node_b = b_reg;
                    req.rd_lvl    = LVL_TOP;
                    state_next    = S_Q_CLIMB;
                end
            end

            S_Q_CLIMB:
            begin
                if (rsp.anc_a != rsp.anc_b)
                begin
                    a_next = rsp.anc_a;
                    b_next = rsp.anc_b;
                end
                total_next = climb_total;
                if (lvl_reg == '0)
                begin
                    res_next   = (climb_total > TW'(PATH_MAX)) ? PATH_MAX
                                                               : climb_total[PATH_W-1:0];
                    state_next = S_Q_EMIT;
                end
                else
                begin
                    req.rd_node_a = (rsp.anc_a != rsp.anc_b) ? rsp.anc_a : a_reg;
                    req.rd_node_b = (rsp.anc_a != rsp.anc_b) ? rsp.anc_b : b_reg;
                    req.rd_lvl    = lvl_reg - LVL_W'(1);
                    lvl_next      = lvl_reg - LVL_W'(1);
                end
            end

            S_Q_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            n_reg         <= '0;
            lvl_reg       <= '0;
            gap_reg       <= '0;
            total_reg     <= '0;
            res_reg       <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            n_reg         <= n_next;
            lvl_reg       <= lvl_next;
            gap_reg       <= gap_next;
            total_reg     <= total_next;
            res_reg       <= res_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

FILE: src/tdbl_store.sv
module tdbl_store #(
    parameter int NODE_COUNT = tdbl_pkg::NODE_COUNT_DEF,
    parameter int LEVELS     = tdbl_pkg::LEVELS_DEF
) (
    input  logic                  clk,
    input  tdbl_pkg::store_req_t  req,
    output tdbl_pkg::store_rsp_t  rsp
);

    import tdbl_pkg::*;

    localparam int NW   = $clog2(NODE_COUNT);
    localparam int LW   = $clog2(LEVELS);
    localparam int AW   = NW + LW;
    localparam int ROWS = NODE_COUNT * (2 ** LW);

    logic [NODE_W-1:0]  anc_mem [0:ROWS-1];
    logic [DEPTH_W-1:0] dep_mem [0:NODE_COUNT-1];

    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic [AW-1:0] wr_addr;

    logic [NODE_W-1:0]  anc_a_reg;
    logic [NODE_W-1:0]  anc_b_reg;
    logic [DEPTH_W-1:0] dep_a_reg;
    logic [DEPTH_W-1:0] dep_b_reg;
    logic               zero_a_reg;
    logic               zero_b_reg;

    assign rd_addr_a = {NW'(req.rd_node_a), req.rd_lvl[LW-1:0]};
    assign rd_addr_b = {NW'(req.rd_node_b), req.rd_lvl[LW-1:0]};
    assign wr_addr   = {NW'(req.wr_node), req.wr_lvl[LW-1:0]};

    always_ff @(posedge clk)
    begin
        if (req.anc_we)
        begin
            anc_mem[wr_addr] <= req.wr_anc;
        end
        if (req.dep_we)
        begin
            dep_mem[NW'(req.wr_node)] <= req.wr_depth;
        end
        anc_a_reg  <= anc_mem[rd_addr_a];
        anc_b_reg  <= anc_mem[rd_addr_b];
        dep_a_reg  <= dep_mem[NW'(req.rd_node_a)];
        dep_b_reg  <= dep_mem[NW'(req.rd_node_b)];
        zero_a_reg <= (req.rd_node_a == '0);
        zero_b_reg <= (req.rd_node_b == '0);
    end

    // sentinel node reads as all zero
    always_comb
    begin
        rsp.anc_a = zero_a_reg ? '0 : clip_node(anc_a_reg, NODE_COUNT);
        rsp.anc_b = zero_b_reg ? '0 : clip_node(anc_b_reg, NODE_COUNT);
        rsp.dep_a = zero_a_reg ? '0 : dep_a_reg;
        rsp.dep_b = zero_b_reg ? '0 : dep_b_reg;
    end

endmodule

FILE: tb/tdbl_distance_checker.sv
`timescale 1ns / 100ps

module tdbl_distance_checker #(
    parameter int NODE_COUNT = tdbl_pkg::NODE_COUNT_DEF,
    parameter int LEVELS     = tdbl_pkg::LEVELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tdbl_chan_if        item,
    tdbl_chan_if        result,
    output int unsigned fail_count,
    output int unsigned pending
);
    import tdbl_pkg::*;

    bit   [NODE_W-1:0]  anc_rows  [NODE_COUNT][LEVELS];
    bit   [DEPTH_W-1:0] depth_mem [NODE_COUNT];
    logic [PATH_W-1:0]  distance_q [$];
    logic [PATH_W-1:0]  want;
    int unsigned        mismatches = 0;
    int unsigned        queued = 0;

    assign fail_count = mismatches;
    assign pending    = queued;

    task automatic report_mismatch(input string what, input logic [PATH_W-1:0] got,
                                   input logic [PATH_W-1:0] wanted);
        $display("%0t mismatch: %s, got %0d, expected %0d", $time, what, got, wanted);
        mismatches++;
    endtask

    function automatic int unsigned fold_node(int unsigned n);
        return (n < NODE_COUNT) ? n : 0;
    endfunction

    function automatic int unsigned step_up(int unsigned n, int lvl);
        return fold_node(32'(anc_rows[fold_node(n)][lvl]));
    endfunction

    function automatic void record_insert(int unsigned node, int unsigned parent_in);
        int unsigned parent;
        int unsigned mid;
        int          lvl;
        if (node == 0 || node >= NODE_COUNT)
            return;
        parent = fold_node(parent_in);
        depth_mem[node] = depth_mem[parent] + DEPTH_W'(1);
        anc_rows[node][0] = NODE_W'(parent);
        for (lvl = 1; lvl < LEVELS; lvl++)
        begin
            mid = step_up(node, lvl - 1);
            anc_rows[node][lvl] = NODE_W'(step_up(mid, lvl - 1));
        end
    endfunction

    function automatic logic [PATH_W-1:0] tree_distance(int unsigned a, int unsigned b);
        int unsigned da;
        int unsigned db;
        int unsigned gap;
        int unsigned total;
        int unsigned swap_node;
        int unsigned ua;
        int unsigned ub;
        int          lvl;
        da = 32'(depth_mem[a]);
        db = 32'(depth_mem[b]);
        if (da < db)
        begin
            swap_node = a;
            a         = b;
            b         = swap_node;
            gap       = db - da;
        end
        else
            gap = da - db;
        for (lvl = LEVELS - 1; lvl >= 0; lvl--)
            if (((gap >> lvl) & 1) != 0)
                a = step_up(a, lvl);
        if (a == b)
            return PATH_W'(gap);
        total = gap;
        for (lvl = LEVELS - 1; lvl >= 0; lvl--)
        begin
            ua = step_up(a, lvl);
            ub = step_up(b, lvl);
            if (ua != ub)
            begin
                a     = ua;
                b     = ub;
                total = total + (2 << lvl);
            end
        end
        total = total + 2;
        return (total > 32'(PATH_MAX)) ? PATH_MAX : PATH_W'(total);
    endfunction

    // results are checked before the item of the same edge is taken in
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (distance_q.size() == 0)
                    report_mismatch("result transaction with no query waiting",
                                    result.data.path_length, '0);
                else
                begin
                    want = distance_q.pop_front();
                    if (result.data.path_length !== want)
                        report_mismatch("path_length", result.data.path_length, want);
                end
            end
            if (item.valid && item.ready)
            begin
                if (item.data.cmd == CMD_QUERY)
                    distance_q = {distance_q,
                                  tree_distance(fold_node(32'(item.data.first_node)),
                                                fold_node(32'(item.data.second_node)))};
                else
                    record_insert(32'(item.data.first_node), 32'(item.data.second_node));
            end
            queued = distance_q.size();
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tdbl_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 2 * LEVELS_DEF + 12;
    localparam int RANDOM_ITEMS = 1400;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        calm  = 1'b0;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count = 0;

    logic [NODE_W-1:0] placed [$];
    bit                placed_map [NODE_COUNT_DEF];

    tdbl_chan_if #(.data_t(item_t))   item_ch ();
    tdbl_chan_if #(.data_t(result_t)) result_ch ();

    tree_distance_binary_lifting i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    tdbl_distance_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge clk)
        result_ch.ready <= calm || ($urandom_range(0, 99) >= 31);

    task automatic send_item(input logic cmd, input logic [NODE_W-1:0] first,
                             input logic [NODE_W-1:0] second);
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= '{cmd: cmd, first_node: first, second_node: second};
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic insert_node(input logic [NODE_W-1:0] node, input logic [NODE_W-1:0] parent);
        send_item(CMD_INSERT, node, parent);
        if (node != 0 && !placed_map[node])
        begin
            placed_map[node] = 1'b1;
            placed = {placed, node};
        end
    endtask

    task automatic hold_until_drained();
        item_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [NODE_W-1:0] pick_placed();
        return placed[$urandom_range(0, placed.size() - 1)];
    endfunction

    initial
    begin
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] parent;
        logic [NODE_W-1:0] qa;
        logic [NODE_W-1:0] qb;
        int unsigned       pick;

        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extremes, sentinel, ignored insert, second root, re-insert, self parent
        insert_node(16'd1, 16'd0);
        insert_node(16'hFFFF, 16'd1);
        insert_node(16'd0, 16'd1);
        insert_node(16'd2, 16'hFFFF);
        insert_node(16'h8000, 16'd2);
        insert_node(16'h7FFF, 16'd1);
        send_item(CMD_QUERY, 16'hFFFF, 16'd1);
        send_item(CMD_QUERY, 16'd1, 16'd1);
        send_item(CMD_QUERY, 16'h8000, 16'h7FFF);
        send_item(CMD_QUERY, 16'h8000, 16'd0);
        send_item(CMD_QUERY, 16'd1, 16'd0);
        insert_node(16'h5555, 16'd0);
        send_item(CMD_QUERY, 16'h5555, 16'h8000);
        insert_node(16'hFFFF, 16'h5555);
        send_item(CMD_QUERY, 16'd2, 16'hFFFF);
        send_item(CMD_QUERY, 16'hFFFF, 16'h5555);
        insert_node(16'h7FFF, 16'h7FFF);
        send_item(CMD_QUERY, 16'h7FFF, 16'h8000);
        send_item(CMD_QUERY, 16'h7FFF, 16'h7FFF);
        insert_node(16'h2AAA, 16'h8000);
        send_item(CMD_QUERY, 16'h2AAA, 16'h5555);
        hold_until_drained();

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            calm <= (k >= 500 && k < 800);
            if (k == 650)
                hold_until_drained();
            pick = $urandom_range(0, 99);
            if (pick < 40 || placed.size() == 0)
            begin
                node = NODE_W'($urandom_range(1, 65535));
                pick = $urandom_range(0, 99);
                if (pick < 10 || placed.size() == 0)
                    parent = '0;
                else if (pick < 55)
                    parent = placed[$];
                else
                    parent = pick_placed();
                insert_node(node, parent);
            end
            else if (pick < 46)
            begin
                qa = pick_placed();
                qb = pick_placed();
                insert_node(qa, qb);
            end
            else if (pick < 50)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_item(CMD_INSERT, '0, pick_placed());
                else
                    send_item(CMD_QUERY, pick_placed(), '0);
            end
            else
            begin
                qa = pick_placed();
                qb = ($urandom_range(0, 9) == 0) ? qa : pick_placed();
                send_item(CMD_QUERY, qa, qb);
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
